// File: hdl/mfpc_pkg.sv
package mfpc_pkg;

  localparam int unsigned COUNT_BITS = 17;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMING_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_HIGH_FIRST = CFG_IDX_W'(1);

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REV = 16'hA001;

  localparam int unsigned MBAP_MIN_LEN   = 8;
  localparam int unsigned MBAP_HDR_LEN   = 6;
  localparam int unsigned MBAP_PDU_START = 7;
  localparam int unsigned MBAP_LEN_HI    = 4;
  localparam int unsigned MBAP_LEN_LO    = 5;
  localparam int unsigned RTU_MIN_LEN    = 6;
  localparam int unsigned RTU_TRAILER    = 2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_MBAP = 2'd1,
    MODE_RTU  = 2'd2
  } framing_mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_LEN_MISM = 2'd2,
    ST_CRC_FAIL = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic       frame_end;
  } res_item_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REV;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/mfpc_res_fifo.sv
module mfpc_res_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    push_num_i,
  input  mfpc_pkg::res_item_t           push_a_i,
  input  mfpc_pkg::res_item_t           push_b_i,
  input  logic                          pop_i,
  output mfpc_pkg::res_item_t           head_o,
  output logic [mfpc_pkg::FIFO_CW-1:0]  level_o
);

  mfpc_pkg::res_item_t               mem_q [mfpc_pkg::FIFO_DEPTH];
  logic [mfpc_pkg::FIFO_AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mfpc_pkg::FIFO_AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mfpc_pkg::FIFO_CW-1:0]      cnt_q, cnt_d;
  logic [mfpc_pkg::FIFO_AW-1:0]      wr_ptr_nx;
  logic                              do_pop;

  assign do_pop    = pop_i && (cnt_q != '0);
  assign wr_ptr_nx = wr_ptr_q + mfpc_pkg::FIFO_AW'(1);
  assign wr_ptr_d  = wr_ptr_q + mfpc_pkg::FIFO_AW'(push_num_i);
  assign rd_ptr_d  = do_pop ? rd_ptr_q + mfpc_pkg::FIFO_AW'(1) : rd_ptr_q;
  assign cnt_d     = cnt_q + mfpc_pkg::FIFO_CW'(push_num_i)
                   - mfpc_pkg::FIFO_CW'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_a_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_b_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign level_o = cnt_q;

endmodule

// File: hdl/modbus_frame_payload_check_core.sv
// modbus frame check and strip, one frame byte per input transfer
// input channel: in_valid_i / in_stall_o with in_data_i (byte plus last-byte mark)
// output channel: out_valid_o / out_stall_i with out_data_o, one result per transfer
// config channel: cfg_valid_i / cfg_ready_o, index 0 framing mode, index 1 crc byte order;
//   write only while the block is idle
// each byte gives at most a payload result and, on the last byte, a status result;
//   payload bytes come out before the status, so drop them when status is not ok
// results are written to a four-entry result queue at the accepting edge and reach
//   out_data_o from the head of that queue
// throughput: one byte per cycle while in_stall_o is low; the byte closing a frame can put two
//   results in the queue, so the single-result output port sets the sustained rate
// in_stall_o rises when the queue holds three or more results, so a stalled
//   receiver holds off the input before the queue can overflow and nothing is lost
// reset clears the queue, the byte counter and mbap length, sets crc to its initial value
//   and resets the config registers (raw mode, crc low byte first)
module modbus_frame_payload_check_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mfpc_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mfpc_pkg::res_item_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mfpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfpc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned CB = mfpc_pkg::COUNT_BITS;

  mfpc_pkg::framing_mode_e       mode_q;
  logic                          crc_hf_q;
  logic [CB-1:0]                 count_q, count_d;
  logic [15:0]                   crc_q, crc_d;
  logic [15:0]                   mbap_len_q, mbap_len_d;
  logic [15:0]                   delay_q;

  logic                          in_xfer;
  logic                          out_xfer;
  logic                          cfg_xfer;
  logic [7:0]                    b;
  logic [7:0]                    old_byte;
  logic                          have_old;
  logic [15:0]                   crc_upd;
  logic [CB:0]                   n_bytes;
  logic [15:0]                   crc_got;
  logic                          pay_emit;
  logic [7:0]                    pay_byte;
  mfpc_pkg::status_e             st;
  mfpc_pkg::res_item_t           pay_res, st_res, push_a, push_b;
  logic [1:0]                    push_num;
  logic [mfpc_pkg::FIFO_CW-1:0]  level;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;

  assign b        = in_data_i.data_byte;
  assign old_byte = delay_q[15:8];
  assign have_old = count_q >= CB'(mfpc_pkg::RTU_TRAILER);
  assign crc_upd  = have_old ? mfpc_pkg::crc16_byte(crc_q, old_byte) : crc_q;
  assign n_bytes  = {1'b0, count_q} + (CB+1)'(1);
  assign crc_got  = crc_hf_q ? {delay_q[7:0], b} : {b, delay_q[7:0]};

  always_comb begin
    mbap_len_d = mbap_len_q;
    if (count_q == CB'(mfpc_pkg::MBAP_LEN_HI)) begin
      mbap_len_d[15:8] = b;
    end else if (count_q == CB'(mfpc_pkg::MBAP_LEN_LO)) begin
      mbap_len_d[7:0] = b;
    end
  end

  always_comb begin
    pay_emit = 1'b1;
    pay_byte = b;
    st       = mfpc_pkg::ST_OK;
    case (mode_q)
      mfpc_pkg::MODE_MBAP: begin
        pay_emit = count_q >= CB'(mfpc_pkg::MBAP_PDU_START);
        if (n_bytes < (CB+1)'(mfpc_pkg::MBAP_MIN_LEN)) begin
          st = mfpc_pkg::ST_SHORT;
        end else if (n_bytes != (CB+1)'(mfpc_pkg::MBAP_HDR_LEN) + (CB+1)'(mbap_len_d)) begin
          st = mfpc_pkg::ST_LEN_MISM;
        end
      end
      mfpc_pkg::MODE_RTU: begin
        pay_emit = have_old;
        pay_byte = old_byte;
        if (n_bytes < (CB+1)'(mfpc_pkg::RTU_MIN_LEN)) begin
          st = mfpc_pkg::ST_SHORT;
        end else if (crc_got != crc_upd) begin
          st = mfpc_pkg::ST_CRC_FAIL;
        end
      end
      default: begin
        pay_emit = 1'b1;
        pay_byte = b;
        st       = mfpc_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    pay_res.item_kind    = mfpc_pkg::KIND_PAYLOAD;
    pay_res.payload_byte = pay_byte;
    pay_res.status       = mfpc_pkg::ST_OK;
    pay_res.frame_end    = 1'b0;
    st_res.item_kind     = mfpc_pkg::KIND_STATUS;
    st_res.payload_byte  = 8'h00;
    st_res.status        = st;
    st_res.frame_end     = 1'b1;
    push_a   = pay_emit ? pay_res : st_res;
    push_b   = st_res;
    push_num = 2'd0;
    if (in_xfer) begin
      push_num = 2'(pay_emit) + 2'(in_data_i.last_byte);
    end
  end

  always_comb begin
    count_d = (count_q != '1) ? count_q + CB'(1) : count_q;
    crc_d   = crc_upd;
    if (in_data_i.last_byte) begin
      count_d = '0;
      crc_d   = mfpc_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= mfpc_pkg::MODE_RAW;
      crc_hf_q   <= 1'b0;
      count_q    <= '0;
      crc_q      <= mfpc_pkg::CRC_INIT;
      mbap_len_q <= '0;
    end else begin
      if (cfg_xfer) begin
        if (cfg_index_i == mfpc_pkg::CFG_FRAMING_MODE) begin
          mode_q <= mfpc_pkg::framing_mode_e'(cfg_wdata_i[1:0]);
        end else if (cfg_index_i == mfpc_pkg::CFG_CRC_HIGH_FIRST) begin
          crc_hf_q <= cfg_wdata_i[0];
        end
      end
      if (in_xfer) begin
        count_q    <= count_d;
        crc_q      <= crc_d;
        mbap_len_q <= in_data_i.last_byte ? 16'h0000 : mbap_len_d;
      end
    end
  end

  // two-byte delay line for the rtu trailer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      delay_q <= {delay_q[7:0], b};
    end
  end

  mfpc_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .push_a_i   (push_a),
    .push_b_i   (push_b),
    .pop_i      (out_xfer),
    .head_o     (out_data_o),
    .level_o    (level)
  );

  assign out_valid_o = level != '0;
  assign in_stall_o  = level > mfpc_pkg::FIFO_CW'(mfpc_pkg::FIFO_DEPTH - 2);

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= mfpc_pkg::FIFO_CW'(mfpc_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.last_byte |=> count_q == '0 && crc_q == mfpc_pkg::CRC_INIT)
    else $error("trackers not cleared after frame end");

  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_kind == mfpc_pkg::KIND_STATUS
    |-> out_data_o.frame_end && out_data_o.payload_byte == 8'h00)
    else $error("malformed status result");

  a_payload_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.item_kind == mfpc_pkg::KIND_PAYLOAD
    |-> !out_data_o.frame_end && out_data_o.status == mfpc_pkg::ST_OK)
    else $error("malformed payload result");
`endif

endmodule
